### src/plcf_pkg.sv
`default_nettype none
package plcf_pkg;

	// Width of the millisecond time base and of the stored start stamp
	localparam int unsigned TimeW   = 32;
	localparam int unsigned PresetW = 32;
	localparam int unsigned ModeW   = 3;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDatW = 32;

	// Timer mode codes
	typedef enum logic [ModeW-1:0] {
		MODE_PULSE    = 3'd0,
		MODE_EXTENDED = 3'd1,
		MODE_ON_DELAY = 3'd2,
		MODE_LATCHED  = 3'd3,
		MODE_OFF_DELAY = 3'd4
	} timer_mode_e;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_TIMER_MODE = 2'd0,
		REG_PRESET_MS  = 2'd1
	} cfg_reg_e;

	// Configuration seen by the evaluation logic
	typedef struct packed {
		logic [ModeW-1:0]   mode;
		logic [PresetW-1:0] preset;
	} cfg_t;

	// Timer state kept between items
	typedef struct packed {
		logic             active;
		logic [TimeW-1:0] stamp;
	} tmr_state_t;

endpackage : plcf_pkg
`default_nettype wire

### src/plcf_cfg.sv
`default_nettype none
module plcf_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [plcf_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [plcf_pkg::CfgDatW-1:0] cfg_data,
	output plcf_pkg::cfg_t                    cfg
);
	import plcf_pkg::*;

	logic [ModeW-1:0]   mode_q;
	logic [PresetW-1:0] preset_q;

	// Writes land directly in the registers, so the port never stalls
	assign cfg_ready = 1'b1;

	// Write the addressed register; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			preset_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIMER_MODE: mode_q   <= cfg_data[ModeW-1:0];
				REG_PRESET_MS:  preset_q <= cfg_data[PresetW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.mode   = mode_q;
	assign cfg.preset = preset_q;

endmodule : plcf_cfg
`default_nettype wire

### src/plcf_eval.sv
`default_nettype none
module plcf_eval (
	input  wire plcf_pkg::cfg_t             cfg,
	input  wire plcf_pkg::tmr_state_t       cur,
	input  wire logic                       start_in,
	input  wire logic                       clear_in,
	input  wire logic [plcf_pkg::TimeW-1:0] now_ms,
	output plcf_pkg::tmr_state_t            nxt,
	output logic                            timer_out
);
	import plcf_pkg::*;

	logic             restamp;
	logic [TimeW-1:0] stamp_use;
	logic [TimeW-1:0] elapsed;
	logic             running;
	logic             act_set;

	// Pick whether this item restarts timing
	always_comb begin
		case (cfg.mode)
			MODE_OFF_DELAY: restamp = start_in;
			MODE_PULSE,
			MODE_EXTENDED,
			MODE_ON_DELAY,
			MODE_LATCHED:   restamp = start_in & ~cur.active;
			default:        restamp = 1'b0;
		endcase
	end

	// Elapsed time wraps with the time base
	assign stamp_use = restamp ? now_ms : cur.stamp;
	assign elapsed   = now_ms - stamp_use;
	assign running   = {{(PresetW-TimeW){1'b0}}, elapsed} < cfg.preset;
	assign act_set   = cur.active | start_in;

	// Apply the mode rules
	always_comb begin
		nxt.stamp  = stamp_use;
		nxt.active = cur.active;
		timer_out  = 1'b0;
		if (clear_in) begin
			nxt.stamp  = cur.stamp;
			nxt.active = 1'b0;
		end else begin
			case (cfg.mode)
				MODE_PULSE: begin
					nxt.active = start_in;
					timer_out  = start_in & running;
				end
				MODE_EXTENDED,
				MODE_ON_DELAY,
				MODE_LATCHED: begin
					if (running) begin
						nxt.active = act_set;
						timer_out  = (cfg.mode == MODE_EXTENDED);
					end else begin
						nxt.active = (!start_in && cfg.mode != MODE_LATCHED) ? 1'b0 : act_set;
						timer_out  = (cfg.mode == MODE_EXTENDED) ? 1'b0 : nxt.active;
					end
				end
				MODE_OFF_DELAY: begin
					nxt.active = running & act_set;
					timer_out  = running & act_set;
				end
				default: begin
					nxt.active = cur.active;
					timer_out  = 1'b0;
				end
			endcase
		end
	end

endmodule : plcf_eval
`default_nettype wire

### src/plc_timer_five_modes_unit.sv
// An accepted item is held in the input register and moves to the result register when the output is free.
// Throughput: one item per cycle while the output is not stalled; the evaluation is one subtract and compare
// between the input register and the result register.
// A stalled result holds in the output register while one more item waits in the input register.
// Reset (arst_n low) clears the active bit, start stamp, mode, preset and all valid flags.
`default_nettype none
module plc_timer_five_modes_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [plcf_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [plcf_pkg::CfgDatW-1:0] cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         start_in,
	input  wire logic                         clear_in,
	input  wire logic [plcf_pkg::TimeW-1:0]   now_ms,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              timer_out
);
	import plcf_pkg::*;

	cfg_t             cfg;
	tmr_state_t       state_q;
	tmr_state_t       state_nxt;
	logic             valid_s1;
	logic             start_s1;
	logic             clear_s1;
	logic [TimeW-1:0] now_s1;
	logic             q_nxt;
	logic             out_valid_q;
	logic             out_q;
	logic             advance;

	plcf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move the item on when the result register is free or being drained
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			start_s1 <= start_in;
			clear_s1 <= clear_in;
			now_s1   <= now_ms;
		end
	end

	plcf_eval u_eval (
		.cfg       (cfg),
		.cur       (state_q),
		.start_in  (start_s1),
		.clear_in  (clear_s1),
		.now_ms    (now_s1),
		.nxt       (state_nxt),
		.timer_out (q_nxt)
	);

	// Commit timer state as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= q_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign timer_out = out_q;

endmodule : plc_timer_five_modes_unit
`default_nettype wire

### src/plcf_checker.sv
`default_nettype none
module plcf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic timer_out
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(timer_out))
		else $error("result changed or vanished while stalled");

	// A result leaves only when taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without being taken");

	// A draining output always lets the next item in
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// An empty result register never blocks the input
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule : plcf_checker

bind plc_timer_five_modes_unit plcf_checker u_plcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.timer_out (timer_out)
);
`default_nettype wire

### tb/sv/plc_timer_five_modes_checker.sv
`default_nettype none
module plc_timer_five_modes_checker
	import plcf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgDatW-1:0] cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               start_in,
	input  wire logic               clear_in,
	input  wire logic [TimeW-1:0]   now_ms,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               timer_out,
	output int                      fail_count,
	output int                      due_count,
	output int                      checked_count,
	output int                      high_count
);

	// Predicted register file and timer state
	logic [ModeW-1:0]   cur_mode;
	logic [PresetW-1:0] cur_preset;
	logic               tmr_active;
	logic [TimeW-1:0]   tmr_stamp;

	// Expected timer_out values, oldest first
	logic timer_out_due[$];

	// Evaluate one item against the predicted state and advance it
	task automatic eval_timer(input logic st, input logic cl, input logic [TimeW-1:0] now,
			output logic q);
		logic [TimeW-1:0] elapsed;
		q = 1'b0;
		if (cl) begin
			tmr_active = 1'b0;
		end else begin
			case (cur_mode)
				MODE_PULSE: begin
					if (!st) begin
						tmr_active = 1'b0;
					end else begin
						if (!tmr_active) begin
							tmr_active = 1'b1;
							tmr_stamp  = now;
						end
						elapsed = now - tmr_stamp;
						q = (elapsed < cur_preset);
					end
				end
				MODE_EXTENDED, MODE_ON_DELAY, MODE_LATCHED: begin
					if (st && !tmr_active) begin
						tmr_active = 1'b1;
						tmr_stamp  = now;
					end
					elapsed = now - tmr_stamp;
					if (elapsed < cur_preset) begin
						q = (cur_mode == MODE_EXTENDED);
					end else begin
						// latched mode keeps its output once expired
						if (!st && cur_mode != MODE_LATCHED)
							tmr_active = 1'b0;
						q = (cur_mode == MODE_EXTENDED) ? 1'b0 : tmr_active;
					end
				end
				MODE_OFF_DELAY: begin
					if (st) begin
						tmr_active = 1'b1;
						tmr_stamp  = now;
					end
					elapsed = now - tmr_stamp;
					if (elapsed < cur_preset) begin
						q = tmr_active;
					end else begin
						tmr_active = 1'b0;
					end
				end
				default: begin
					// spare mode codes hold state and give zero
					q = 1'b0;
				end
			endcase
		end
	endtask

	// Watch the three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		logic exp_q;
		logic pred_q;
		if (!arst_n) begin
			cur_mode      = MODE_PULSE;
			cur_preset    = '0;
			tmr_active    = 1'b0;
			tmr_stamp     = '0;
			timer_out_due.delete();
			fail_count    = 0;
			checked_count = 0;
			high_count    = 0;
			due_count     = 0;
		end else begin
			// apply register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIMER_MODE: cur_mode = cfg_data[ModeW-1:0];
					REG_PRESET_MS:  cur_preset = cfg_data[PresetW-1:0];
					default: ;
				endcase
			end
			// compare an accepted result before queuing a new item
			if (out_valid && out_ready) begin
				if (timer_out_due.size() == 0) begin
					$error("unexpected result: timer_out expected none, actual %0b", timer_out);
					fail_count++;
				end else begin
					exp_q = timer_out_due.pop_front();
					checked_count++;
					if (timer_out !== exp_q) begin
						$error("timer_out mismatch: expected %0b, actual %0b", exp_q, timer_out);
						fail_count++;
					end
					if (exp_q)
						high_count++;
				end
			end
			// predict an accepted item
			if (in_valid && in_ready) begin
				eval_timer(start_in, clear_in, now_ms, pred_q);
				timer_out_due.push_back(pred_q);
			end
			due_count = timer_out_due.size();
		end
	end

endmodule : plc_timer_five_modes_checker
`default_nettype wire

### tb/sv/plc_timer_five_modes_unit_tb.sv
`default_nettype none
module plc_timer_five_modes_unit_tb;
	import plcf_pkg::*;

	localparam int RAND_ITEMS  = 1600;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;

	// Index codes with no register behind them
	localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 2'd3;
	// Mode codes outside the defined set
	localparam logic [ModeW-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [ModeW-1:0] MODE_SPARE_LAST  = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDatW-1:0] cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               start_in;
	logic               clear_in;
	logic [TimeW-1:0]   now_ms;
	logic               out_valid;
	logic               out_ready;
	logic               timer_out;

	int fail_count;
	int due_count;
	int checked_count;
	int high_count;

	int items_sent;
	int cfg_writes;
	bit calm;
	bit hold_done;
	int quiet_cycles;

	plc_timer_five_modes_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start_in  (start_in),
		.clear_in  (clear_in),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.timer_out (timer_out)
	);

	plc_timer_five_modes_checker timer_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_in      (start_in),
		.clear_in      (clear_in),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.timer_out     (timer_out),
		.fail_count    (fail_count),
		.due_count     (due_count),
		.checked_count (checked_count),
		.high_count    (high_count)
	);

	// Free-running clock, period 2
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one evaluation item and hold it until accepted
	task automatic offer_eval(input logic st, input logic cl, input logic [TimeW-1:0] now);
		@(negedge clk);
		while (!calm && $urandom_range(99, 0) < 29) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		start_in = st;
		clear_in = cl;
		now_ms   = now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Write one register through the configuration channel
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_writes++;
	endtask

	// Drop the input and wait until every expected result has come back
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Load mode and preset while the block is idle, in random order
	task automatic configure(input logic [CfgDatW-1:0] mode_word, input logic [PresetW-1:0] preset);
		settle();
		if ($urandom_range(1, 0)) begin
			write_reg(REG_TIMER_MODE, mode_word);
			write_reg(REG_PRESET_MS, preset);
		end else begin
			write_reg(REG_PRESET_MS, preset);
			write_reg(REG_TIMER_MODE, mode_word);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off while the sender keeps going
	initial begin
		out_ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_ready = calm ? 1'b1 : ($urandom_range(99, 0) >= 29);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("timeout after %0d idle cycles", quiet_cycles);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		timer_mode_e        mode_seq[5];
		logic [ModeW-1:0]   mode;
		logic [CfgDatW-1:0] mode_word;
		logic [PresetW-1:0] preset;
		logic [TimeW-1:0]   t;
		logic [TimeW-1:0]   now;
		logic               set_lvl;
		logic               clr;
		int unsigned        lim;
		int                 phase;
		int                 phase_len;
		int                 rand_items;
		int                 k;
		int                 r;

		mode_seq     = '{MODE_PULSE, MODE_EXTENDED, MODE_ON_DELAY, MODE_LATCHED, MODE_OFF_DELAY};
		quiet_cycles = 0;
		items_sent   = 0;
		cfg_writes   = 0;
		calm         = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_TIMER_MODE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		start_in     = 1'b0;
		clear_in     = 1'b0;
		now_ms       = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Pulse at reset settings, then preset 10 with a wrap of the time base
		offer_eval(1'b1, 1'b0, 32'd7);
		configure(CfgDatW'(MODE_PULSE), 32'd10);
		offer_eval(1'b1, 1'b0, 32'd100);
		offer_eval(1'b1, 1'b0, 32'd109);
		offer_eval(1'b1, 1'b0, 32'd110);
		offer_eval(1'b0, 1'b0, 32'd111);
		offer_eval(1'b1, 1'b0, 32'hFFFF_FFFA);
		offer_eval(1'b1, 1'b0, 32'd3);
		offer_eval(1'b1, 1'b1, 32'd4);

		// Zero preset: extended pulse never runs
		configure(CfgDatW'(MODE_EXTENDED), 32'd0);
		offer_eval(1'b1, 1'b0, 32'd5);
		offer_eval(1'b0, 1'b0, 32'd6);

		// On-delay at the largest preset, expiring on the last count
		configure(CfgDatW'(MODE_ON_DELAY), 32'hFFFF_FFFF);
		offer_eval(1'b1, 1'b0, 32'd0);
		offer_eval(1'b1, 1'b0, 32'hFFFF_FFFE);
		offer_eval(1'b1, 1'b0, 32'hFFFF_FFFF);

		// Latched on-delay keeps its output after set drops
		configure(CfgDatW'(MODE_LATCHED), 32'd3);
		offer_eval(1'b1, 1'b0, 32'd10);
		offer_eval(1'b0, 1'b0, 32'd20);
		offer_eval(1'b0, 1'b1, 32'd21);

		// Off-delay runs out after set drops, using the stale stamp
		configure(CfgDatW'(MODE_OFF_DELAY), 32'd5);
		offer_eval(1'b1, 1'b0, 32'd50);
		offer_eval(1'b0, 1'b0, 32'd54);
		offer_eval(1'b0, 1'b0, 32'd55);

		// Spare mode code with junk in the upper data bits, and unused indexes
		configure({29'h1A5A_5A5A, MODE_SPARE_LAST}, 32'd8);
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);
		offer_eval(1'b1, 1'b0, 32'd1);
		offer_eval(1'b1, 1'b1, 32'd2);
		offer_eval(1'b0, 1'b0, 32'd3);

		// Random phases: each mode and preset setting, then random modes; time sweeps with off-sweep noise items
		phase      = 0;
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			if (phase < 5)
				mode = mode_seq[phase];
			else if ($urandom_range(99, 0) < 12)
				mode = ModeW'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
			else
				mode = ModeW'($urandom_range(MODE_OFF_DELAY, MODE_PULSE));
			case (phase % 6)
				0:       preset = '0;
				1:       preset = 32'd1;
				2:       preset = $urandom_range(40, 2);
				3:       preset = '1;
				4:       preset = $urandom;
				default: preset = $urandom_range(5000, 100);
			endcase
			mode_word = CfgDatW'(mode);
			if ($urandom_range(3, 0) == 0) begin
				mode_word = $urandom;
				mode_word[ModeW-1:0] = mode;
			end
			configure(mode_word, preset);

			// start some phases just below the wrap point
			t       = (phase % 3 == 0) ? ('1 - $urandom_range(100, 0)) : $urandom;
			set_lvl = 1'($urandom_range(1, 0));
			if (preset == 0)
				lim = 4;
			else if (preset < 200)
				lim = preset / 3 + 1;
			else
				lim = 60;
			phase_len = $urandom_range(100, 60);
			for (k = 0; k < phase_len && rand_items < RAND_ITEMS; k++) begin
				calm = (rand_items >= 800 && rand_items < 1000);
				r = $urandom_range(99, 0);
				if (r < 8) begin
					// noise: an arbitrary time off the sweep
					now = $urandom;
				end else begin
					if (r < 16)
						t = t + preset - 2 + $urandom_range(4, 0);
					else
						t = t + $urandom_range(lim, 0);
					now = t;
				end
				if ($urandom_range(4, 0) == 0)
					set_lvl = !set_lvl;
				clr = ($urandom_range(24, 0) == 0);
				offer_eval(set_lvl, clr, now);
				rand_items++;
			end
			phase++;
		end
		calm = 1'b0;

		settle();
		repeat (6) @(negedge clk);
		$display("Ran %0d timer evaluations across %0d register writes and %0d phases.",
			items_sent, cfg_writes, phase);
		$display("Checked %0d results (%0d high), including one %0d-cycle output stall.",
			checked_count, high_count, HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule : plc_timer_five_modes_unit_tb
`default_nettype wire

### files.f
src/plcf_pkg.sv
src/plcf_cfg.sv
src/plcf_eval.sv
src/plc_timer_five_modes_unit.sv
src/plcf_checker.sv
tb/sv/plc_timer_five_modes_checker.sv
tb/sv/plc_timer_five_modes_unit_tb.sv
